@@ src/ray_box_slab_intersect_defines.svh @@
// Assertion helpers used by the ray/box slab intersect module.
// Each macro expects clk and rst_n in scope.
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rbs_pkg.sv @@
package rbs_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_AXES        = 3;
    localparam int CFG_INDEX_WIDTH = 3;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CORNER_A_X,
        CFG_CORNER_A_Y,
        CFG_CORNER_A_Z,
        CFG_CORNER_B_X,
        CFG_CORNER_B_Y,
        CFG_CORNER_B_Z
    } cfg_index_t;

endpackage

@@ src/rbs_ray_if.sv @@
interface rbs_ray_if #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        input  ready
    );

    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
        output ready
    );
endinterface

@@ src/rbs_hit_if.sv @@
interface rbs_hit_if #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          hit_flag;
    logic signed [COORD_WIDTH-1:0] near_dist;
    logic signed [COORD_WIDTH-1:0] entry_x;
    logic signed [COORD_WIDTH-1:0] entry_y;
    logic signed [COORD_WIDTH-1:0] entry_z;

    modport source (
        output valid, hit_flag, near_dist, entry_x, entry_y, entry_z,
        input  ready
    );

    modport sink (
        input  valid, hit_flag, near_dist, entry_x, entry_y, entry_z,
        output ready
    );
endinterface

@@ src/ray_box_slab_intersect.sv @@
// Channel   Modport  Carries
// ray       sink     origin_x/y/z, dir_x/y/z (signed fixed point)
// result    source   hit_flag, near_dist, entry_x/y/z
// cfg_*     write    box corners, index 0..5, ignored above 5
//
// One ray per cycle while result is not stalled; each ray passes through the
// six slab dividers, which resolve one quotient bit per pipeline stage, and
// then the back-end stages before its result appears.
// Reset clears the valid bits and loads the default box (0 to 1.0).
// A stall on result freezes the whole pipeline; nothing is dropped.
`include "ray_box_slab_intersect_defines.svh"

module ray_box_slab_intersect #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    rbs_ray_if.sink                             ray,
    rbs_hit_if.source                           result
);
    import rbs_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int RW   = W + 1 + F;
    localparam int NL   = 2 * NUM_AXES;
    localparam int LAST = W + 6;

    localparam logic [W-1:0]   MAXV  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]   MINV  = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] PCAP2 = {{W{1'b0}}, MAXV};
    localparam logic [2*W-1:0] NCAP2 = {{W{1'b0}}, MINV};

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [W-1:0]  den;
        logic [W-1:0]  quo;
        logic          neg;
        logic          ovf;
    } div_lane_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][W-1:0] org;
        logic [NUM_AXES-1:0][W-1:0] dir;
    } ray_t;

    logic [W-1:0] corner_a_reg [NUM_AXES];
    logic [W-1:0] corner_b_reg [NUM_AXES];

    logic                 vld_reg  [0:LAST];
    ray_t                 ray_reg  [0:LAST-1];
    div_lane_t [NL-1:0]   lane_reg [0:W];
    ray_t                 ray_in;
    div_lane_t [NL-1:0]   lane_in;
    logic                 en;

    logic [NL-1:0][W-1:0]       t_reg;
    logic [NUM_AXES-1:0][W-1:0] lo_reg;
    logic [NUM_AXES-1:0][W-1:0] hi_reg;
    logic [W-1:0]               near_reg;
    logic [W-1:0]               far_reg;
    logic [NUM_AXES-1:0][2*W-1:0] prod_reg;
    logic [NUM_AXES-1:0]        pneg_reg;
    logic                       hit4_reg;
    logic [W-1:0]               near4_reg;
    logic [NUM_AXES-1:0][W-1:0] pr_reg;
    logic                       hit5_reg;
    logic [W-1:0]               near5_reg;

    logic                       out_hit_reg;
    logic [W-1:0]               out_near_reg;
    logic [NUM_AXES-1:0][W-1:0] out_entry_reg;

    // Advance whenever the output slot is free or being taken
    assign en        = !vld_reg[LAST] || result.ready;
    assign ray.ready = en;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                corner_a_reg[a] <= '0;
                corner_b_reg[a] <= W'(1) << F;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CORNER_A_X: corner_a_reg[0] <= cfg_data;
                CFG_CORNER_A_Y: corner_a_reg[1] <= cfg_data;
                CFG_CORNER_A_Z: corner_a_reg[2] <= cfg_data;
                CFG_CORNER_B_X: corner_b_reg[0] <= cfg_data;
                CFG_CORNER_B_Y: corner_b_reg[1] <= cfg_data;
                CFG_CORNER_B_Z: corner_b_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Gather the input item
    always_comb
    begin
        ray_in.org[0] = ray.origin_x;
        ray_in.org[1] = ray.origin_y;
        ray_in.org[2] = ray.origin_z;
        ray_in.dir[0] = ray.dir_x;
        ray_in.dir[1] = ray.dir_y;
        ray_in.dir[2] = ray.dir_z;
    end

    // Set up the six divisions: magnitudes, sign and overflow check
    always_comb
    begin
        logic [W:0]   diff;
        logic [W:0]   amag;
        logic [W-1:0] dnz;
        logic [W-1:0] bmag;
        logic [W-1:0] cor;
        for (int l = 0; l < NL; l++)
        begin
            cor  = (l % 2 == 0) ? corner_a_reg[l / 2] : corner_b_reg[l / 2];
            diff = {cor[W-1], cor} - {ray_in.org[l / 2][W-1], ray_in.org[l / 2]};
            dnz  = (ray_in.dir[l / 2] == '0) ? W'(1) : ray_in.dir[l / 2];
            amag = diff[W] ? (~diff + 1'b1) : diff;
            bmag = dnz[W-1] ? (~dnz + 1'b1) : dnz;
            lane_in[l].rem = {amag, {F{1'b0}}};
            lane_in[l].den = bmag;
            lane_in[l].quo = '0;
            lane_in[l].neg = diff[W] ^ dnz[W-1];
            lane_in[l].ovf = (amag >> (W - F)) >= {1'b0, bmag};
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= ray.valid;
            for (int k = 0; k < LAST; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end
    end

    // Carry the ray alongside the arithmetic
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray_reg[0]  <= ray_in;
            lane_reg[0] <= lane_in;
            for (int k = 0; k < LAST - 1; k++)
            begin
                ray_reg[k+1] <= ray_reg[k];
            end
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 0; k < W; k++)
    begin : g_div
        localparam int SH = W - 1 - k;
        div_lane_t [NL-1:0] lane_next;

        always_comb
        begin
            for (int l = 0; l < NL; l++)
            begin
                lane_next[l] = lane_reg[k][l];
                if ((lane_reg[k][l].rem >> SH) >= RW'(lane_reg[k][l].den))
                begin
                    lane_next[l].rem = lane_reg[k][l].rem - (RW'(lane_reg[k][l].den) << SH);
                    lane_next[l].quo[SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lane_reg[k+1] <= lane_next;
            end
        end
    end

    // Back-end stages: saturate, sort, reduce, multiply, scale, add
    always_ff @(posedge clk)
    begin
        logic [W-1:0]   q;
        logic           over;
        logic [W-1:0]   nmag;
        logic [W-1:0]   dmag;
        logic [W-1:0]   nv;
        logic [W-1:0]   fv;
        logic [2*W-1:0] sh;
        logic [W:0]     sum;
        if (en)
        begin
            // Saturate and sign the quotients
            for (int l = 0; l < NL; l++)
            begin
                q    = lane_reg[W][l].quo;
                over = lane_reg[W][l].neg ? (q[W-1] && (|q[W-2:0])) : q[W-1];
                if (lane_reg[W][l].ovf || over)
                begin
                    t_reg[l] <= lane_reg[W][l].neg ? MINV : MAXV;
                end
                else
                begin
                    t_reg[l] <= lane_reg[W][l].neg ? (~q + 1'b1) : q;
                end
            end

            // Order each slab pair
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if ($signed(t_reg[2*a]) > $signed(t_reg[2*a+1]))
                begin
                    lo_reg[a] <= t_reg[2*a+1];
                    hi_reg[a] <= t_reg[2*a];
                end
                else
                begin
                    lo_reg[a] <= t_reg[2*a];
                    hi_reg[a] <= t_reg[2*a+1];
                end
            end

            // Largest near, smallest far
            nv = lo_reg[0];
            fv = hi_reg[0];
            for (int a = 1; a < NUM_AXES; a++)
            begin
                if ($signed(lo_reg[a]) > $signed(nv))
                begin
                    nv = lo_reg[a];
                end
                if ($signed(hi_reg[a]) < $signed(fv))
                begin
                    fv = hi_reg[a];
                end
            end
            near_reg <= nv;
            far_reg  <= fv;

            // Hit test and direction times near
            hit4_reg  <= !(($signed(near_reg) > $signed(far_reg)) || far_reg[W-1]);
            near4_reg <= near_reg;
            nmag = near_reg[W-1] ? (~near_reg + 1'b1) : near_reg;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                dmag = ray_reg[W+3].dir[a][W-1] ? (~ray_reg[W+3].dir[a] + 1'b1)
                                                : ray_reg[W+3].dir[a];
                prod_reg[a] <= {{W{1'b0}}, nmag} * {{W{1'b0}}, dmag};
                pneg_reg[a] <= near_reg[W-1] ^ ray_reg[W+3].dir[a][W-1];
            end

            // Scale the products and saturate
            hit5_reg  <= hit4_reg;
            near5_reg <= near4_reg;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sh = prod_reg[a] >> F;
                if (pneg_reg[a] ? (sh > NCAP2) : (sh > PCAP2))
                begin
                    pr_reg[a] <= pneg_reg[a] ? MINV : MAXV;
                end
                else
                begin
                    pr_reg[a] <= pneg_reg[a] ? (~sh[W-1:0] + 1'b1) : sh[W-1:0];
                end
            end

            // Add the origin, saturate, zero on a miss
            out_hit_reg  <= hit5_reg;
            out_near_reg <= hit5_reg ? near5_reg : '0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sum = {ray_reg[W+5].org[a][W-1], ray_reg[W+5].org[a]}
                    + {pr_reg[a][W-1], pr_reg[a]};
                if (!hit5_reg)
                begin
                    out_entry_reg[a] <= '0;
                end
                else if (sum[W] != sum[W-1])
                begin
                    out_entry_reg[a] <= sum[W] ? MINV : MAXV;
                end
                else
                begin
                    out_entry_reg[a] <= sum[W-1:0];
                end
            end
        end
    end

    // Drive the result channel
    assign result.valid     = vld_reg[LAST];
    assign result.hit_flag  = out_hit_reg;
    assign result.near_dist = out_near_reg;
    assign result.entry_x   = out_entry_reg[0];
    assign result.entry_y   = out_entry_reg[1];
    assign result.entry_z   = out_entry_reg[2];

    // A miss carries all-zero fields
    `RBS_ASSERT_IMPL(a_miss_zero, result.valid && !result.hit_flag,
        result.near_dist == '0 && result.entry_x == '0 && result.entry_y == '0
        && result.entry_z == '0, "miss result with nonzero fields")

    // A stall freezes the pipeline
    `RBS_ASSERT_NEXT(a_stall_hold, !en,
        vld_reg[0] == $past(vld_reg[0]) && vld_reg[W] == $past(vld_reg[W]),
        "pipeline moved during a stall")

    // A taken ray enters the first stage
    `RBS_ASSERT_NEXT(a_accept_enter, ray.valid && ray.ready, vld_reg[0],
        "accepted ray not captured")

endmodule
